FILE: rtl/sk_pkg.sv
// ----------------------------------------------------------------------------
// sk_pkg
// Shared types and codes for the sorted key table: opcodes, status codes,
// the entry record and the command and flag groups that pass between cells.
// ----------------------------------------------------------------------------
package sk_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 16;
  localparam int NAME_W     = 64;
  localparam int YEAR_W     = 16;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int CAPACITY_D = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [YEAR_W-1:0] year;
  } entry_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    logic   insert;   // committed insert this cycle
    logic   remove;   // committed remove this cycle
    entry_t ent;      // incoming entry; key also drives the compares
  } cell_cmd_t;

  // Per-cell compare results.
  typedef struct packed {
    logic occ;        // cell holds a live entry
    logic gt;         // live and key above the incoming key
    logic eq;         // live and key equal to the incoming key
  } cell_flag_t;

endpackage

FILE: rtl/sk_cell.sv
// ----------------------------------------------------------------------------
// sk_cell
// One slot of the sorted table. Holds an entry, compares it against the
// broadcast key and takes its left or right neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module sk_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  sk_pkg::cell_cmd_t  cmd,
  input  logic [CNT_W-1:0]   count,
  input  sk_pkg::entry_t     left_ent,
  input  logic               left_gt,
  input  sk_pkg::entry_t     right_ent,
  output sk_pkg::entry_t     ent,
  output sk_pkg::cell_flag_t flags
);
  import sk_pkg::*;

  logic occ;
  logic at_end;
  logic gt;
  logic ge;

  assign occ    = CNT_W'(IDX) < count;
  assign at_end = CNT_W'(IDX) == count;
  assign gt     = occ && (ent.key > cmd.ent.key);
  assign ge     = occ && (ent.key >= cmd.ent.key);

  assign flags.occ = occ;
  assign flags.gt  = gt;
  assign flags.eq  = occ && (ent.key == cmd.ent.key);

  // Insert: slide up behind the insertion point, load the new entry at it.
  // Remove: slide down from the matching slot onward.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (left_gt) begin
        ent <= left_ent;
      end else if (gt || at_end) begin
        ent <= cmd.ent;
      end
    end else if (cmd.remove && ge) begin
      ent <= right_ent;
    end
  end

endmodule

FILE: rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Fixed-capacity table of (key, name tag, year) entries kept in ascending
// key order, with insert, remove-by-key and read-at-position operations.
// ----------------------------------------------------------------------------
// The table takes one operation in every clock cycle: busy stays low, so a
// transaction is accepted at every edge where start is high. The answer
// appears on the result ports in the next cycle, marked by done for exactly
// that one cycle; the receiver cannot stall it and must capture it then.
// No pipeline is needed because the entries live in a row of CAPACITY cells,
// each comparing its own key against the broadcast key in parallel and
// shifting to or from its neighbor in the same edge. entry_count is the
// fill after the operation, modulo 32. key_out, name_out and year_out are
// zero except on a successful read. Opcode 3 changes nothing and answers
// ok with the current count.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int CAPACITY = sk_pkg::CAPACITY_D
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sk_pkg::OP_W-1:0]      opcode,
  input  logic [sk_pkg::KEY_W-1:0]     key,
  input  logic [sk_pkg::NAME_W-1:0]    name_tag,
  input  logic [sk_pkg::YEAR_W-1:0]    year,
  input  logic [sk_pkg::POS_W-1:0]     position,
  output logic                         done,
  output logic [sk_pkg::STATUS_W-1:0]  status,
  output logic [sk_pkg::COUNT_W-1:0]   entry_count,
  output logic [sk_pkg::KEY_W-1:0]     key_out,
  output logic [sk_pkg::NAME_W-1:0]    name_out,
  output logic [sk_pkg::YEAR_W-1:0]    year_out
);
  import sk_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Fill count: entries live in cells 0 .. count-1.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  opcode_t    op;
  cell_cmd_t  cmd;
  entry_t     cell_ent  [CAPACITY];
  cell_flag_t cell_flag [CAPACITY];
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] sel_vec;
  logic [CAPACITY-1:0] sorted_ok;

  logic    full;
  logic    empty;
  logic    hit;
  logic    pos_ok;
  status_t status_next;
  entry_t  read_ent;
  entry_t  new_ent;

  assign busy  = 1'b0;
  assign op    = opcode_t'(opcode);
  assign full  = count == CNT_W'(CAPACITY);
  assign empty = count == '0;
  assign hit   = |eq_vec;
  assign pos_ok = CMP_W'(position) < CMP_W'(count);

  assign new_ent.key  = key;
  assign new_ent.name = name_tag;
  assign new_ent.year = year;

  // Decode the transaction and resolve the status before the cells commit.
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    cmd.insert  = 1'b0;
    cmd.remove  = 1'b0;
    cmd.ent     = new_ent;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (hit) begin
          status_next = ST_DUP;
        end else begin
          cmd.insert = start;
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (!hit) begin
          status_next = ST_MISSING;
        end else begin
          cmd.remove = start;
          count_next = count - 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Row of cells; each cell sees its neighbors' entries and its left
  // neighbor's "greater" flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_ent[i-1];
      assign left_gt  = gt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    sk_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .left_ent  (left_ent),
      .left_gt   (left_gt),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .flags     (cell_flag[i])
    );

    assign gt_vec[i]  = cell_flag[i].gt;
    assign eq_vec[i]  = cell_flag[i].eq;
    assign sel_vec[i] = CMP_W'(i) == CMP_W'(position);

    if (i == CAPACITY - 1) begin : g_sort_last
      assign sorted_ok[i] = 1'b1;
    end else begin : g_sort
      assign sorted_ok[i] = !cell_flag[i+1].occ ||
                            (cell_ent[i].key < cell_ent[i+1].key);
    end
  end

  // Read port: one-hot select over the cells.
  always_comb begin
    read_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_vec[i]) begin
        read_ent = read_ent | cell_ent[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  // Result register; zero the data fields unless a read succeeds.
  always_ff @(posedge clk) begin
    if (start) begin
      status <= status_next;
      if (op == OP_READ && pos_ok) begin
        key_out  <= read_ent.key;
        name_out <= read_ent.name;
        year_out <= read_ent.year;
      end else begin
        key_out  <= '0;
        name_out <= '0;
        year_out <= '0;
      end
    end
  end

  assign entry_count = COUNT_W'(count);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("accepted transaction not answered next cycle");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &sorted_ok)
    else $error("live keys not strictly ascending");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (start && op == OP_INSERT && status_next == ST_OK) |=>
      (count == CNT_W'($past(count) + 1'b1)))
    else $error("successful insert did not grow the table");

endmodule

FILE: tb/sorted_key_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches the command and result ports of the sorted key table, keeps its own
// sorted copy of the table, predicts the answer to every accepted transaction
// and compares each answer field by field as it comes out.
// ----------------------------------------------------------------------------
module sorted_key_table_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [sk_pkg::OP_W-1:0]     opcode,
  input  logic [sk_pkg::KEY_W-1:0]    key,
  input  logic [sk_pkg::NAME_W-1:0]   name_tag,
  input  logic [sk_pkg::YEAR_W-1:0]   year,
  input  logic [sk_pkg::POS_W-1:0]    position,
  input  logic                        done,
  input  logic [sk_pkg::STATUS_W-1:0] status,
  input  logic [sk_pkg::COUNT_W-1:0]  entry_count,
  input  logic [sk_pkg::KEY_W-1:0]    key_out,
  input  logic [sk_pkg::NAME_W-1:0]   name_out,
  input  logic [sk_pkg::YEAR_W-1:0]   year_out,
  output int                          fail_count,
  output int                          answers_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import sk_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [YEAR_W-1:0]  year;
  } table_answer_t;

  logic [KEY_W-1:0]  shadow_keys  [CAPACITY_D];
  logic [NAME_W-1:0] shadow_names [CAPACITY_D];
  logic [YEAR_W-1:0] shadow_years [CAPACITY_D];
  int                shadow_fill;
  table_answer_t     answers_due [$];

  initial begin
    fail_count      = 0;
    answers_waiting = 0;
    shadow_fill     = 0;
  end

  // Apply one operation to the shadow table and return the answer it earns.
  function automatic table_answer_t apply_table_op(opcode_t op, logic [KEY_W-1:0] k,
                                                   logic [NAME_W-1:0] tag,
                                                   logic [YEAR_W-1:0] yr,
                                                   logic [POS_W-1:0] pos);
    table_answer_t ans;
    int            hit;
    int            slot;
    ans = '0;
    ans.status = ST_OK;
    hit = shadow_fill;
    slot = shadow_fill;
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_keys[i] == k) hit = i;
      if (shadow_keys[i] > k) slot = i;
    end
    case (op)
      OP_INSERT: begin
        if (shadow_fill >= CAPACITY_D) begin
          ans.status = ST_FULL;
        end else if (hit < shadow_fill) begin
          ans.status = ST_DUP;
        end else begin
          for (int i = shadow_fill; i > slot; i--) begin
            shadow_keys[i]  = shadow_keys[i-1];
            shadow_names[i] = shadow_names[i-1];
            shadow_years[i] = shadow_years[i-1];
          end
          shadow_keys[slot]  = k;
          shadow_names[slot] = tag;
          shadow_years[slot] = yr;
          shadow_fill++;
        end
      end
      OP_REMOVE: begin
        if (shadow_fill == 0) begin
          ans.status = ST_EMPTY;
        end else if (hit >= shadow_fill) begin
          ans.status = ST_MISSING;
        end else begin
          for (int i = hit; i + 1 < shadow_fill; i++) begin
            shadow_keys[i]  = shadow_keys[i+1];
            shadow_names[i] = shadow_names[i+1];
            shadow_years[i] = shadow_years[i+1];
          end
          shadow_fill--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= shadow_fill) begin
          ans.status = ST_RANGE;
        end else begin
          ans.key  = shadow_keys[pos];
          ans.name = shadow_names[pos];
          ans.year = shadow_years[pos];
        end
      end
      default: ;
    endcase
    ans.count = shadow_fill[COUNT_W-1:0];
    return ans;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Retire the pending answer before predicting a new one: the block answers in
  // the cycle after it accepts, so both can happen at the same edge.
  always @(posedge clk) begin
    table_answer_t want;
    if (rst) begin
      shadow_fill = 0;
      answers_due.delete();
    end else begin
      if (done === 1'b1) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t result with no transaction outstanding", $time);
        end else begin
          want = answers_due.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("entry_count", 64'(want.count), 64'(entry_count));
          check_field("key_out", 64'(want.key), 64'(key_out));
          check_field("name_out", want.name, name_out);
          check_field("year_out", 64'(want.year), 64'(year_out));
        end
      end
      if (start && !busy)
        answers_due.push_back(apply_table_op(opcode_t'(opcode), key, name_tag, year,
                                             position));
    end
    answers_waiting <= answers_due.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted key table with a short directed sequence and then long
// insert-heavy and remove-heavy random stretches over a small key pool, so
// that the table fills, empties, meets duplicates and misses. A checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sk_pkg::*;

  localparam int RANDOM_OPS  = 800;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     opcode = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [NAME_W-1:0]   name_tag = '0;
  logic [YEAR_W-1:0]   year = '0;
  logic [POS_W-1:0]    position = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic [KEY_W-1:0]    key_out;
  logic [NAME_W-1:0]   name_out;
  logic [YEAR_W-1:0]   year_out;

  int fail_count;
  int answers_waiting;
  int cycle_count = 0;
  int idle_pct = 0;       // chance, in percent, that the sender holds off a cycle
  int insert_pct = 60;    // share of inserts in the current random stretch

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_key_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .key(key), .name_tag(name_tag), .year(year), .position(position),
    .done(done), .status(status), .entry_count(entry_count),
    .key_out(key_out), .name_out(name_out), .year_out(year_out)
  );

  sorted_key_table_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .key(key), .name_tag(name_tag), .year(year), .position(position),
    .done(done), .status(status), .entry_count(entry_count),
    .key_out(key_out), .name_out(name_out), .year_out(year_out),
    .fail_count(fail_count), .answers_waiting(answers_waiting)
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Present one transaction at a falling edge, after a random number of idle
  // cycles, and hold it until a rising edge accepts it. start is assigned once
  // per falling edge, so back-to-back transactions keep it high.
  task automatic issue_op(opcode_t op, logic [KEY_W-1:0] k, logic [NAME_W-1:0] tag,
                          logic [YEAR_W-1:0] yr, logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    opcode   <= op;
    key      <= k;
    name_tag <= tag;
    year     <= yr;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly draw from a pool of 24 keys, larger than the capacity, so that
  // duplicates, hits on remove and a full table are common; the rest spread
  // over the whole key range and its extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75)
      return KEY_W'($urandom_range(23) * 2731 + 5);
    else if (roll < 80)
      return '0;
    else if (roll < 85)
      return '1;
    else
      return KEY_W'($urandom);
  endfunction

  task automatic random_op();
    int roll;
    opcode_t op;
    roll = $urandom_range(99);
    if (roll < 3)
      op = OP_RSVD;
    else if (roll < 3 + insert_pct)
      op = OP_INSERT;
    else if (roll < 78)
      op = OP_REMOVE;
    else
      op = OP_READ;
    issue_op(op, pick_key(), {$urandom, $urandom}, YEAR_W'($urandom),
             POS_W'($urandom_range(15)));
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: the empty table first, then extremes of every field.
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd0);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd15);
    issue_op(OP_REMOVE, 16'h1234, '0, '0, 4'd0);
    issue_op(OP_RSVD,   16'hFFFF, '1, '1, 4'd15);
    issue_op(OP_INSERT, 16'hFFFF, '1, 16'hFFFF, 4'd15);
    issue_op(OP_INSERT, 16'h0000, '0, 16'h0000, 4'd0);
    issue_op(OP_INSERT, 16'h0000, 64'hA5A5_A5A5_A5A5_A5A5, 16'h1111, 4'd0);
    issue_op(OP_INSERT, 16'h8000, 64'h8000_0000_0000_0001, 16'h7FFF, 4'd0);
    issue_op(OP_INSERT, 16'h7FFF, 64'h0123_4567_89AB_CDEF, 16'h8000, 4'd0);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd0);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd1);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd2);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd3);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd4);
    issue_op(OP_RSVD,   16'h0000, '0, '0, 4'd0);
    issue_op(OP_REMOVE, 16'h4444, '0, '0, 4'd0);
    issue_op(OP_REMOVE, 16'h7FFF, '0, '0, 4'd0);
    issue_op(OP_REMOVE, 16'h0000, '0, '0, 4'd0);
    issue_op(OP_READ,   16'h0000, '0, '0, 4'd0);
    issue_op(OP_REMOVE, 16'hFFFF, '0, '0, 4'd0);
    issue_op(OP_REMOVE, 16'h8000, '0, '0, 4'd0);
    issue_op(OP_REMOVE, 16'h8000, '0, '0, 4'd0);

    // Random: three idling regimes, with insert-heavy and remove-heavy
    // stretches so the table swings between full and empty.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n < RANDOM_OPS / 3)
        idle_pct = 36;
      else if (n < 2 * RANDOM_OPS / 3)
        idle_pct = 47;
      else
        idle_pct = 0;
      if (n % 40 == 0)
        insert_pct = $urandom_range(1) ? 60 : 20;
      random_op();
    end

    // Drop start, drain the outstanding answer, then keep watching for stray
    // results.
    @(negedge clk);
    start <= 1'b0;
    while (answers_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
